>>> design/ipt_pkg.sv
package ipt_pkg;
  localparam int NUM_SLOTS_DEF = 32;
  localparam int TS_W = 64;
  localparam int CNT_W = 32;
  // per-slot record: running, start, count, total, min, max, mean, m2
  localparam int REC_W = 1 + 64 + 32 + 64 * 5;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_END   = 2'd1,
    KIND_COUNT = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SLOT = 3'd1,
    ST_WRONG    = 3'd2,
    ST_TWICE    = 3'd3,
    ST_NO_BEGIN = 3'd4
  } status_t;

  typedef struct packed {
    logic        running;
    logic [63:0] start;
    logic [31:0] count;
    logic [63:0] total;
    logic [63:0] tmin;
    logic [63:0] tmax;
    logic [63:0] mean;
    logic [63:0] m2;
  } rec_t;

  localparam rec_t REC_RESET = '{running: 1'b0, start: '0, count: '0, total: '0,
                                 tmin: '1, tmax: '0, mean: '0, m2: '0};
endpackage

>>> design/interval_profiler_table.sv
// channel  role    transaction contents
// in_      slave   tuser: kind; tdata: slot, timestamp
// out_     master  status and slot statistics after the item
// cfg_     apb     slots_in_use (0x0), interval_slot_mask (0x4)
//
// one item at a time: slot record read from ram, evaluated, written back
// read or rejected item: eval goes straight to the out step, which loads the result;
// accepted begin or count: a second eval pass writes the record back first
// accepted end: eval is followed by the restoring divide of the mean delta by
// the count and the four-step partial-product multiply for the m2 term
// after reset a clearing pass writes every ram entry, one per cycle, taking no
// item; a waiting result holds off only the next item's result, not its intake
module interval_profiler_table import ipt_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] kind
  input  logic [1:0]   in_tuser,
  // [4:0] slot, [68:5] timestamp, zero fill to 72
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [34:3] event_count, [98:35] total_time, [162:99] min_time,
  // [226:163] max_time, [290:227] mean_time, [354:291] squared_dev_sum,
  // [418:355] last_elapsed, [450:419] update_total, zero fill to 456
  output logic [455:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RAM_D = 1 << AW;

  localparam logic [2:0] ADDR_SLOTS = 3'h0;
  localparam logic [2:0] ADDR_MASK  = 3'h4;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_EVAL, S_DIV, S_MUL, S_OUT} state_t;

  state_t      state_r;
  logic [5:0]  slots_r;
  logic [31:0] mask_r;
  logic [31:0] gupd_r;
  logic [AW-1:0] clr_r;
  kind_t       kind_r;
  logic [4:0]  slot_r;
  logic [63:0] ts_r;
  rec_t        rec_r;
  logic [63:0] el_r, e_r, d1_r;
  logic        up_r;
  logic [2:0]  st_r;
  logic        bad_r;
  logic [455:0] out_r;
  logic        out_vld_r;

  // ram port
  logic          we;
  logic [AW-1:0] waddr, raddr;
  rec_t          wrec, rrec;

  ipt_ram #(.WIDTH(REC_W), .DEPTH(RAM_D)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wrec), .raddr(raddr), .rdata(rrec)
  );

  // divider and multiplier
  logic        div_start, div_done, mul_start, mul_done;
  logic [63:0] quot;
  logic [127:0] prod;
  logic [31:0] ndiv;
  logic [63:0] mean_new, d2;
  logic [63:0] d1_in;

  assign ndiv = (rec_r.count == 32'd0) ? 32'd1 : rec_r.count;

  ipt_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(d1_in),
                 .divisor(ndiv), .done(div_done), .quotient(quot));

  always_comb begin
    mean_new = (e_r >= rec_r.mean) ? rec_r.mean + quot : rec_r.mean - quot;
    d2 = (e_r >= mean_new) ? e_r - mean_new : mean_new - e_r;
  end

  ipt_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mul_start), .a(d1_r), .b(d2),
                 .done(mul_done), .prod(prod));

  // configuration
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (cfg_paddr)
      ADDR_SLOTS: cfg_prdata = {26'd0, slots_r};
      ADDR_MASK:  cfg_prdata = mask_r;
      default:    cfg_prdata = 32'd0;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata = out_r;
  assign raddr = AW'(in_tdata[4:0]);

  // evaluation of the record read for the held item
  logic        slot_ok, is_timer;
  logic [63:0] el, e_in, sum, min_n, max_n;
  logic [31:0] cnt_inc;
  logic [64:0] m2_sum;
  logic [63:0] m2_inc;

  always_comb begin
    slot_ok  = ({1'b0, slot_r} < slots_r) && (32'(slot_r) < 32'(NUM_SLOTS));
    is_timer = mask_r[slot_r];
    el       = ts_r - rec_r.start;
    e_in     = (el[63:48] != 16'd0) ? '1 : {el[47:0], 16'd0};
    d1_in    = (e_in >= rec_r.mean) ? e_in - rec_r.mean : rec_r.mean - e_in;
    sum      = rec_r.total + el;
    cnt_inc  = (rec_r.count == '1) ? rec_r.count : rec_r.count + 32'd1;
    min_n    = (rec_r.tmin > el) ? el : rec_r.tmin;
    max_n    = (rec_r.tmax < el) ? el : rec_r.tmax;
    m2_inc   = (prod[127:96] != 32'd0) ? '1 : prod[95:32];
    m2_sum   = {1'b0, rec_r.m2} + {1'b0, m2_inc};
  end

  always_comb begin
    we = 1'b0;
    waddr = AW'(slot_r);
    wrec = rec_r;
    div_start = (state_r == S_EVAL) && !bad_r && kind_r == KIND_END && st_r == ST_OK
                && slot_ok && is_timer && rec_r.running;
    mul_start = (state_r == S_DIV) && div_done;
    if (state_r == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_r;
      wrec = REC_RESET;
    end else if (state_r == S_EVAL && up_r) begin
      we = 1'b1;
    end else if (state_r == S_MUL && mul_done) begin
      we = 1'b1;
      wrec.mean = mean_new;
      wrec.m2 = m2_sum[64] ? '1 : m2_sum[63:0];
    end
  end

  // the eval step computes the status and state update of every item here; an end's mean and m2 follow div and mul
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      slots_r   <= '0;
      mask_r    <= '0;
      gupd_r    <= '0;
      out_vld_r <= 1'b0;
      up_r      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr == ADDR_SLOTS) slots_r <= cfg_pwdata[5:0];
        else if (cfg_paddr == ADDR_MASK) mask_r <= cfg_pwdata;
      end
      if (state_r == S_OUT && (!out_vld_r || out_tready)) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == RAM_D - 1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            ts_r    <= in_tdata[68:5];
            kind_r  <= kind_t'(in_tuser);
            slot_r  <= in_tdata[4:0];
            state_r <= S_READ;
          end
        end
        S_READ: begin
          rec_r   <= rrec;
          bad_r   <= 1'b0;
          up_r    <= 1'b0;
          el_r    <= 64'd0;
          st_r    <= ST_OK;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (bad_r) begin
            // second pass of eval after an update: written back, then report
            up_r    <= 1'b0;
            state_r <= S_OUT;
          end else if (!slot_ok) begin
            st_r    <= ST_BAD_SLOT;
            state_r <= S_OUT;
          end else begin
            unique case (kind_r)
              KIND_BEGIN: begin
                if (!is_timer) begin
                  st_r    <= ST_WRONG;
                  state_r <= S_OUT;
                end else if (rec_r.running) begin
                  st_r    <= ST_TWICE;
                  state_r <= S_OUT;
                end else begin
                  rec_r.running <= 1'b1;
                  rec_r.start <= ts_r;
                  gupd_r <= gupd_r + 32'd1;
                  up_r <= 1'b1;
                  state_r <= S_EVAL;
                  bad_r <= 1'b1;
                end
              end
              KIND_END: begin
                if (!is_timer) begin
                  st_r    <= ST_WRONG;
                  state_r <= S_OUT;
                end else if (!rec_r.running) begin
                  st_r    <= ST_NO_BEGIN;
                  state_r <= S_OUT;
                end else begin
                  el_r <= el;
                  e_r <= e_in;
                  d1_r <= d1_in;
                  gupd_r <= gupd_r + 32'd1;
                  rec_r.count <= cnt_inc;
                  rec_r.total <= (sum < rec_r.total) ? '1 : sum;
                  rec_r.tmin <= min_n;
                  rec_r.tmax <= max_n;
                  rec_r.running <= 1'b0;
                  rec_r.start <= 64'd0;
                  state_r <= S_DIV;
                end
              end
              KIND_COUNT: begin
                if (is_timer) begin
                  st_r    <= ST_WRONG;
                  state_r <= S_OUT;
                end else begin
                  rec_r.count <= cnt_inc;
                  gupd_r <= gupd_r + 32'd1;
                  up_r <= 1'b1;
                  state_r <= S_EVAL;
                  bad_r <= 1'b1;
                end
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_DIV: if (div_done) state_r <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            rec_r.mean <= mean_new;
            rec_r.m2 <= m2_sum[64] ? '1 : m2_sum[63:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_vld_r || out_tready) begin
            if (st_r == ST_BAD_SLOT)
              out_r <= {5'd0, gupd_r, 384'd0, 32'd0, st_r};
            else
              out_r <= {5'd0, gupd_r, el_r, rec_r.m2, rec_r.mean, rec_r.tmax,
                        rec_r.tmin, rec_r.total, rec_r.count, st_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_tready) else $error("accept during clearing pass");
  a_div_mul_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_start && mul_start)) else $error("divider and multiplier started together");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
endmodule

>>> design/ipt_ram.sv
module ipt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> design/ipt_div.sv
// restoring divider, one quotient bit per cycle
module ipt_div import ipt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_r[31:0], q_r[63]};
    trial   = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        rem_r  <= '0;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        if (!trial[32]) begin
          rem_r <= trial;
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = q_r;
endmodule

>>> design/ipt_mul.sv
// 64x64 product from four 32x32 partial products
module ipt_mul import ipt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);
  logic [63:0]  a_r, b_r;
  logic [127:0] acc_r;
  logic [2:0]   step_r;
  logic         busy_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp_r;
  logic [1:0]   pp_sel_r;
  logic         pp_vld_r;
  logic [127:0] pp_shift;

  always_comb begin
    pa = step_r[0] ? a_r[63:32] : a_r[31:0];
    pb = step_r[1] ? b_r[63:32] : b_r[31:0];
    unique case (pp_sel_r)
      2'd0:    pp_shift = {64'd0, pp_r};
      2'd3:    pp_shift = {pp_r, 64'd0};
      default: pp_shift = {32'd0, pp_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done     <= 1'b0;
      pp_vld_r <= 1'b0;
      step_r   <= '0;
    end else begin
      done     <= 1'b0;
      pp_vld_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else begin
        if (busy_r) begin
          pp_r     <= pa * pb;
          pp_sel_r <= step_r[1:0];
          pp_vld_r <= 1'b1;
          step_r   <= step_r + 3'd1;
          if (step_r == 3'd3) busy_r <= 1'b0;
        end
        if (pp_vld_r) begin
          acc_r <= acc_r + pp_shift;
          if (pp_sel_r == 2'd3) done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc_r;
endmodule
